>>> hw/rtl/ppf_pkg.sv
`timescale 1ns / 1ps
package ppf_pkg;

    // Position and force words are signed fixed point of the same format.
    localparam int POS_W  = 24;
    localparam int DIFF_W = POS_W + 1;
    localparam int OUT_W  = 24;
    localparam int CUT_W  = 19;

    // Register port geometry.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register indexes, as decoded from bit 2 of the byte address.
    localparam logic REG_CUTOFF = 1'b0;

    // Cutoff after reset: 0.17, unsigned with 20 fraction bits (UQ0.20 in a 19-bit field).
    localparam logic [CUT_W-1:0] CUTOFF_RESET = 19'd178258;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [OUT_W-1:0] t_force;

endpackage

>>> hw/rtl/ppf_in_if.sv
`timescale 1ns / 1ps
interface ppf_in_if import ppf_pkg::*; ();

    logic valid;
    logic ready;
    t_pos a_x;
    t_pos a_y;
    t_pos a_z;
    t_pos b_x;
    t_pos b_y;
    t_pos b_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);

endinterface

>>> hw/rtl/ppf_out_if.sv
`timescale 1ns / 1ps
interface ppf_out_if import ppf_pkg::*; ();

    logic   valid;
    logic   ready;
    t_force force_x;
    t_force force_y;
    t_force force_z;
    logic   within_cutoff;
    logic   coincident;

    modport source (output valid, force_x, force_y, force_z, within_cutoff, coincident,
                    input ready);
    modport sink (input valid, force_x, force_y, force_z, within_cutoff, coincident,
                  output ready);

endinterface

>>> hw/rtl/pairwise_particle_force_unit.sv
// Throughput: one word per cycle; the pipeline advances as a whole whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (synchronous, active low) restores the cutoff and rebuilds the force table,
// one entry per cycle, with the input held not ready meanwhile.
`timescale 1ns / 1ps
module pairwise_particle_force_unit import ppf_pkg::*; #(
    parameter int FRAC_BITS       = 20,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppf_in_if.sink            i_pos,
    ppf_out_if.source         o_force,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int RW      = DIFF_W;
    localparam int RAD_W   = 2 * RW;
    localparam int AW      = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FR_W    = FRAC_BITS - 1;
    localparam int TW      = 34;
    localparam int GW      = TW + 1;
    localparam int IDX_W   = RW + AW;
    localparam int POS_PW  = IDX_W + FR_W;
    localparam int PROD_W  = GW + FR_W + 1;
    localparam int NUM_W   = GW + DIFF_W;
    localparam int DEN_W   = CUT_W + 30 - FRAC_BITS;
    localparam int SQ_SW   = 3 * DIFF_W + 1;
    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
    localparam longint DEP = longint'(EXP_TABLE_DEPTH);

    // Per-step decay factors exp(-30/DEPTH) and exp(-15/DEPTH) in Q30, each a Taylor sum up to
    // the twentieth-power term, whose terms are truncated toward zero.
    localparam longint T60_1  = (Q30_ONE * 30) / DEP;
    localparam longint T60_2  = (T60_1 * 30) / (DEP * 2);
    localparam longint T60_3  = (T60_2 * 30) / (DEP * 3);
    localparam longint T60_4  = (T60_3 * 30) / (DEP * 4);
    localparam longint T60_5  = (T60_4 * 30) / (DEP * 5);
    localparam longint T60_6  = (T60_5 * 30) / (DEP * 6);
    localparam longint T60_7  = (T60_6 * 30) / (DEP * 7);
    localparam longint T60_8  = (T60_7 * 30) / (DEP * 8);
    localparam longint T60_9  = (T60_8 * 30) / (DEP * 9);
    localparam longint T60_10 = (T60_9 * 30) / (DEP * 10);
    localparam longint T60_11 = (T60_10 * 30) / (DEP * 11);
    localparam longint T60_12 = (T60_11 * 30) / (DEP * 12);
    localparam longint T60_13 = (T60_12 * 30) / (DEP * 13);
    localparam longint T60_14 = (T60_13 * 30) / (DEP * 14);
    localparam longint T60_15 = (T60_14 * 30) / (DEP * 15);
    localparam longint T60_16 = (T60_15 * 30) / (DEP * 16);
    localparam longint T60_17 = (T60_16 * 30) / (DEP * 17);
    localparam longint T60_18 = (T60_17 * 30) / (DEP * 18);
    localparam longint T60_19 = (T60_18 * 30) / (DEP * 19);
    localparam longint T60_20 = (T60_19 * 30) / (DEP * 20);

    localparam longint T30_1  = (Q30_ONE * 15) / DEP;
    localparam longint T30_2  = (T30_1 * 15) / (DEP * 2);
    localparam longint T30_3  = (T30_2 * 15) / (DEP * 3);
    localparam longint T30_4  = (T30_3 * 15) / (DEP * 4);
    localparam longint T30_5  = (T30_4 * 15) / (DEP * 5);
    localparam longint T30_6  = (T30_5 * 15) / (DEP * 6);
    localparam longint T30_7  = (T30_6 * 15) / (DEP * 7);
    localparam longint T30_8  = (T30_7 * 15) / (DEP * 8);
    localparam longint T30_9  = (T30_8 * 15) / (DEP * 9);
    localparam longint T30_10 = (T30_9 * 15) / (DEP * 10);
    localparam longint T30_11 = (T30_10 * 15) / (DEP * 11);
    localparam longint T30_12 = (T30_11 * 15) / (DEP * 12);
    localparam longint T30_13 = (T30_12 * 15) / (DEP * 13);
    localparam longint T30_14 = (T30_13 * 15) / (DEP * 14);
    localparam longint T30_15 = (T30_14 * 15) / (DEP * 15);
    localparam longint T30_16 = (T30_15 * 15) / (DEP * 16);
    localparam longint T30_17 = (T30_16 * 15) / (DEP * 17);
    localparam longint T30_18 = (T30_17 * 15) / (DEP * 18);
    localparam longint T30_19 = (T30_18 * 15) / (DEP * 19);
    localparam longint T30_20 = (T30_19 * 15) / (DEP * 20);

    localparam logic [30:0] R60 = 31'(Q30_ONE - T60_1 + T60_2 - T60_3 + T60_4 - T60_5
        + T60_6 - T60_7 + T60_8 - T60_9 + T60_10 - T60_11 + T60_12 - T60_13 + T60_14
        - T60_15 + T60_16 - T60_17 + T60_18 - T60_19 + T60_20);
    localparam logic [30:0] R30 = 31'(Q30_ONE - T30_1 + T30_2 - T30_3 + T30_4 - T30_5
        + T30_6 - T30_7 + T30_8 - T30_9 + T30_10 - T30_11 + T30_12 - T30_13 + T30_14
        - T30_15 + T30_16 - T30_17 + T30_18 - T30_19 + T30_20);

    typedef enum logic {ST_FILL, ST_RUN} t_state;

    t_state               r_state;
    logic [AW-1:0]        r_fill_idx;
    logic [30:0]          r_e60;
    logic [30:0]          r_e30;
    logic signed [TW-1:0] r_mem [EXP_TABLE_DEPTH+1];
    logic [CUT_W-1:0]     r_cutoff;

    logic [61:0]          w_e60_prod;
    logic [61:0]          w_e30_prod;
    logic [63:0]          w_div5;
    logic signed [TW-1:0] w_entry;
    logic                 w_en;
    logic                 w_acc_in;

    // ------------------------------------------------------------------
    // Register port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CUTOFF) ? APB_DW'(r_cutoff) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CUTOFF) begin
            r_cutoff <= pwdata[CUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Force table build after reset: two decaying exponentials by recurrence.
    // ------------------------------------------------------------------
    assign w_e60_prod = 62'(r_e60) * 62'(R60);
    assign w_e30_prod = 62'(r_e30) * 62'(R30);
    assign w_div5     = 64'({1'b0, r_e30} + 32'd2) * 64'(RECIP5);
    assign w_entry    = TW'({1'b0, r_e60, 2'b00}) - TW'(w_div5[63:34]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_fill_idx <= '0;
            r_e60      <= 31'(Q30_ONE);
            r_e30      <= 31'(Q30_ONE);
        end else begin
            case (r_state)
                ST_FILL: begin
                    r_e60      <= 31'((w_e60_prod + (62'd1 << 29)) >> 30);
                    r_e30      <= 31'((w_e30_prod + (62'd1 << 29)) >> 30);
                    r_fill_idx <= r_fill_idx + 1'b1;
                    if (r_fill_idx == AW'(EXP_TABLE_DEPTH)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves when the output register can take a word.
    // ------------------------------------------------------------------
    logic r_out_vld;

    assign w_en        = !r_out_vld || o_force.ready;
    assign i_pos.ready = w_en && (r_state == ST_RUN);
    assign w_acc_in    = i_pos.valid && i_pos.ready;

    // ------------------------------------------------------------------
    // Differences, squares and their sum.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] r_d0 [3];
    logic signed [DIFF_W-1:0] r_d1 [3];
    logic signed [DIFF_W-1:0] r_d2 [3];
    logic [RAD_W-1:0]         r_sq [3];
    logic signed [RAD_W-1:0]  w_sq [3];
    logic [RAD_W-1:0]         r_sum;
    logic                     r_co1;
    logic                     r_co2;
    logic                     r_v0;
    logic                     r_v1;
    logic                     r_v2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sq[k] = RAD_W'(r_d0[k]) * RAD_W'(r_d0[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0[0] <= DIFF_W'(i_pos.b_x) - DIFF_W'(i_pos.a_x);
            r_d0[1] <= DIFF_W'(i_pos.b_y) - DIFF_W'(i_pos.a_y);
            r_d0[2] <= DIFF_W'(i_pos.b_z) - DIFF_W'(i_pos.a_z);
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= unsigned'(w_sq[k]);
                r_d1[k] <= r_d0[k];
                r_d2[k] <= r_d1[k];
            end
            r_co1 <= (r_d0[0] == '0) && (r_d0[1] == '0) && (r_d0[2] == '0);
            r_co2 <= r_co1;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // ------------------------------------------------------------------
    // Distance by a bit-per-stage square root.
    // ------------------------------------------------------------------
    logic                     w_rt_vld;
    logic [RW-1:0]            w_root;
    logic [SQ_SW-1:0]         w_rt_side;
    logic signed [DIFF_W-1:0] w_rt_dk [3];
    logic                     w_rt_co;

    ppf_sqrt_pipe #(
        .RW (RW),
        .SW (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_rad   (r_sum),
        .i_side  ({r_co2, r_d2[2], r_d2[1], r_d2[0]}),
        .o_valid (w_rt_vld),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    assign w_rt_dk[0] = signed'(w_rt_side[DIFF_W-1:0]);
    assign w_rt_dk[1] = signed'(w_rt_side[2*DIFF_W-1:DIFF_W]);
    assign w_rt_dk[2] = signed'(w_rt_side[3*DIFF_W-1:2*DIFF_W]);
    assign w_rt_co    = w_rt_side[SQ_SW-1];

    // ------------------------------------------------------------------
    // Table address and interpolation fraction; past the table end use the last entry.
    // ------------------------------------------------------------------
    logic [POS_PW-1:0] w_pos;
    logic [IDX_W-1:0]  w_idx;
    logic              w_past;

    assign w_pos  = POS_PW'(w_root) * POS_PW'(EXP_TABLE_DEPTH);
    assign w_idx  = w_pos[POS_PW-1:FR_W];
    assign w_past = w_idx >= IDX_W'(EXP_TABLE_DEPTH);

    logic [AW-1:0]            r_alo;
    logic [AW-1:0]            r_ahi;
    logic [FR_W-1:0]          r_frA;
    logic [FR_W-1:0]          r_frB;
    logic [CUT_W-1:0]         r_dA;
    logic [CUT_W-1:0]         r_dB;
    logic [CUT_W-1:0]         r_dC;
    logic [CUT_W-1:0]         r_dD;
    logic signed [DIFF_W-1:0] r_dkA [3];
    logic signed [DIFF_W-1:0] r_dkB [3];
    logic signed [DIFF_W-1:0] r_dkC [3];
    logic signed [DIFF_W-1:0] r_dkD [3];
    logic                     r_wA, r_wB, r_wC, r_wD, r_wE;
    logic                     r_coA, r_coB, r_coC, r_coD, r_coE;
    logic                     r_vA, r_vB, r_vC, r_vD, r_vE;
    logic signed [TW-1:0]     r_lo;
    logic signed [TW-1:0]     r_hi;
    logic signed [TW-1:0]     r_loC;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [GW-1:0]     r_g;
    logic signed [NUM_W-1:0]  r_num [3];
    logic [DEN_W-1:0]         r_denE;

    // Memory: write port for the table build, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FILL) begin
            r_mem[r_fill_idx] <= w_entry;
        end
        if (w_en) begin
            r_lo <= r_mem[r_alo];
            r_hi <= r_mem[r_ahi];
        end
    end

    // Interpolation product and the rounded correction.
    logic signed [GW-1:0]     w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_pmag;
    logic [PROD_W-1:0]        w_rq;
    logic signed [GW-1:0]     w_rqs;
    logic signed [GW-1:0]     w_g;

    assign w_diff = GW'(r_hi) - GW'(r_lo);
    assign w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, r_frB}));
    assign w_pmag = r_prod[PROD_W-1] ? unsigned'(-r_prod) : unsigned'(r_prod);
    assign w_rq   = (w_pmag + (PROD_W'(1) << (FR_W - 1))) >> FR_W;
    assign w_rqs  = signed'(GW'(w_rq));
    assign w_g    = GW'(r_loC) + (r_prod[PROD_W-1] ? -w_rqs : w_rqs);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage A: cutoff test and addresses.
            r_wA  <= w_root <= RW'(r_cutoff);
            r_coA <= w_rt_co;
            r_dA  <= w_root[CUT_W-1:0];
            if (w_past) begin
                r_alo <= AW'(EXP_TABLE_DEPTH);
                r_ahi <= AW'(EXP_TABLE_DEPTH);
                r_frA <= '0;
            end else begin
                r_alo <= w_idx[AW-1:0];
                r_ahi <= w_idx[AW-1:0] + 1'b1;
                r_frA <= w_pos[FR_W-1:0];
            end
            // Stage B: table read in flight.
            r_frB <= r_frA;
            r_wB  <= r_wA;
            r_coB <= r_coA;
            r_dB  <= r_dA;
            // Stage C: slope times fraction.
            r_prod <= w_prod;
            r_loC  <= r_lo;
            r_wC   <= r_wB;
            r_coC  <= r_coB;
            r_dC   <= r_dB;
            // Stage D: interpolated scalar force.
            r_g  <= w_g;
            r_wD <= r_wC;
            r_coD <= r_coC;
            r_dD <= r_dC;
            // Stage E: numerators and the common divisor.
            r_denE <= DEN_W'(r_dD) << (30 - FRAC_BITS);
            r_wE   <= r_wD;
            r_coE  <= r_coD;
            for (int k = 0; k < 3; k++) begin
                r_dkA[k] <= w_rt_dk[k];
                r_dkB[k] <= r_dkA[k];
                r_dkC[k] <= r_dkB[k];
                r_dkD[k] <= r_dkC[k];
                r_num[k] <= NUM_W'(r_g) * NUM_W'(r_dkD[k]);
            end
        end
    end

    // Valid bits of the top-level stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vA <= 1'b0;
            r_vB <= 1'b0;
            r_vC <= 1'b0;
            r_vD <= 1'b0;
            r_vE <= 1'b0;
        end else if (w_en) begin
            r_v0 <= w_acc_in;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_vA <= w_rt_vld;
            r_vB <= r_vA;
            r_vC <= r_vB;
            r_vD <= r_vC;
            r_vE <= r_vD;
        end
    end

    // ------------------------------------------------------------------
    // Division by the distance, rounded and saturated.
    // ------------------------------------------------------------------
    logic       w_dv_vld;
    t_force     w_quot [3];
    logic [1:0] w_dv_side;

    ppf_div_pipe #(
        .NW (NUM_W),
        .DW (DEN_W),
        .SW (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vE),
        .i_num   (r_num),
        .i_den   (r_denE),
        .i_side  ({r_wE, r_coE}),
        .o_valid (w_dv_vld),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    // ------------------------------------------------------------------
    // Output register; no force outside the cutoff or for coincident positions.
    // ------------------------------------------------------------------
    logic   r_within;
    logic   r_coinc;
    t_force r_force [3];
    logic   w_apply;

    assign w_apply = w_dv_side[1] && !w_dv_side[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_within <= w_dv_side[1];
            r_coinc  <= w_dv_side[0];
            for (int k = 0; k < 3; k++) begin
                r_force[k] <= w_apply ? w_quot[k] : '0;
            end
        end
    end

    assign o_force.valid         = r_out_vld;
    assign o_force.force_x       = r_force[0];
    assign o_force.force_y       = r_force[1];
    assign o_force.force_z       = r_force[2];
    assign o_force.within_cutoff = r_within;
    assign o_force.coincident    = r_coinc;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_force.valid && (!o_force.within_cutoff || o_force.coincident) |->
            o_force.force_x == '0 && o_force.force_y == '0 && o_force.force_z == '0)
        else $error("force not zero outside cutoff or for coincident positions");

    a_coinc_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_force.valid && o_force.coincident |-> o_force.within_cutoff)
        else $error("coincident word not flagged within cutoff");

    a_no_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FILL |-> !i_pos.ready)
        else $error("input taken while the force table is being built");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_force.ready |=> r_out_vld && $stable(r_force[0]) && $stable(r_vE))
        else $error("pipeline moved during an output stall");

endmodule

>>> hw/rtl/ppf_sqrt_pipe.sv
`timescale 1ns / 1ps
module ppf_sqrt_pipe import ppf_pkg::*; #(
    parameter int RW = 25,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int REM_W = RW + 3;

    logic [2*RW-1:0]  r_rad  [RW];
    logic [REM_W-1:0] r_rem  [RW];
    logic [RW-1:0]    r_root [RW];
    logic [SW-1:0]    r_side [RW];
    logic             r_vld  [RW];
    logic [2*RW-1:0]  n_rad  [RW];
    logic [REM_W-1:0] n_rem  [RW];
    logic [RW-1:0]    n_root [RW];

    // One root bit per stage: bring down two radicand bits and try the next bit.
    always_comb begin
        logic [2*RW-1:0]  v_rad;
        logic [REM_W-1:0] v_rem;
        logic [REM_W-1:0] v_acc;
        logic [REM_W-1:0] v_trial;
        logic [RW-1:0]    v_root;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                v_rad  = i_rad;
                v_rem  = '0;
                v_root = '0;
            end else begin
                v_rad  = r_rad[k-1];
                v_rem  = r_rem[k-1];
                v_root = r_root[k-1];
            end
            v_acc   = {v_rem[REM_W-3:0], v_rad[2*RW-1 -: 2]};
            v_trial = {1'b0, v_root, 2'b01};
            if (v_acc >= v_trial) begin
                n_rem[k]  = v_acc - v_trial;
                n_root[k] = {v_root[RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_acc;
                n_root[k] = {v_root[RW-2:0], 1'b0};
            end
            n_rad[k] = {v_rad[2*RW-3:0], 2'b00};
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < RW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < RW; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < RW; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

>>> hw/rtl/ppf_div_pipe.sv
`timescale 1ns / 1ps
module ppf_div_pipe import ppf_pkg::*; #(
    parameter int NW = 60,
    parameter int DW = 29,
    parameter int SW = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num [3],
    input  logic [DW-1:0]        i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output t_force               o_quot [3],
    output logic [SW-1:0]        o_side
);

    localparam int QW = OUT_W;
    localparam int AW = NW + 1;
    localparam int HW = (AW - QW > DW) ? AW - QW : DW;
    localparam logic [QW-1:0] POS_LIM = QW'((2 ** (OUT_W - 1)) - 1);
    localparam logic [QW-1:0] NEG_LIM = QW'(2 ** (OUT_W - 1));

    // Front stage: magnitude plus half the divisor, for rounding half away from zero.
    logic [AW-1:0] r_add  [3];
    logic          r_neg0 [3];
    logic [DW-1:0] r_den0;
    logic [SW-1:0] r_side0;
    logic          r_v0;
    logic [AW-1:0] n_add  [3];

    // Quotient stages; index 0 holds the overflow check and the first partial remainder.
    logic [DW-1:0] r_rem  [QW+1][3];
    logic [QW-1:0] r_q    [QW+1][3];
    logic [QW-1:0] r_low  [QW+1][3];
    logic          r_ovf  [QW+1][3];
    logic          r_neg  [QW+1][3];
    logic [DW-1:0] r_den  [QW+1];
    logic [SW-1:0] r_side [QW+1];
    logic          r_vld  [QW+1];
    logic [DW-1:0] n_rem  [QW+1][3];
    logic [QW-1:0] n_q    [QW+1][3];
    logic          n_ovf  [3];

    always_comb begin
        logic [NW-1:0] v_mag;
        for (int l = 0; l < 3; l++) begin
            v_mag    = i_num[l][NW-1] ? NW'(-i_num[l]) : NW'(i_num[l]);
            n_add[l] = AW'(v_mag) + AW'(i_den >> 1);
        end
    end

    // The quotient must fit QW bits; anything larger saturates anyway.
    // After that, restoring division, one quotient bit per stage.
    always_comb begin
        logic [HW-1:0] v_hi;
        logic [DW:0]   v_acc;
        for (int l = 0; l < 3; l++) begin
            v_hi        = HW'(r_add[l][AW-1:QW]);
            n_ovf[l]    = v_hi >= HW'(r_den0);
            n_rem[0][l] = v_hi[DW-1:0];
            n_q[0][l]   = '0;
        end
        for (int j = 1; j <= QW; j++) begin
            for (int l = 0; l < 3; l++) begin
                v_acc = {r_rem[j-1][l], r_low[j-1][l][QW-j]};
                if (v_acc >= {1'b0, r_den[j-1]}) begin
                    n_rem[j][l] = DW'(v_acc - {1'b0, r_den[j-1]});
                    n_q[j][l]   = {r_q[j-1][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[j][l] = DW'(v_acc);
                    n_q[j][l]   = {r_q[j-1][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v0     <= i_valid;
            r_vld[0] <= r_v0;
            for (int j = 1; j <= QW; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den0   <= i_den;
            r_side0  <= i_side;
            r_den[0] <= r_den0;
            r_side[0] <= r_side0;
            for (int l = 0; l < 3; l++) begin
                r_add[l]     <= n_add[l];
                r_neg0[l]    <= i_num[l][NW-1];
                r_rem[0][l]  <= n_rem[0][l];
                r_q[0][l]    <= n_q[0][l];
                r_low[0][l]  <= r_add[l][QW-1:0];
                r_ovf[0][l]  <= n_ovf[l];
                r_neg[0][l]  <= r_neg0[l];
            end
            for (int j = 1; j <= QW; j++) begin
                r_den[j]  <= r_den[j-1];
                r_side[j] <= r_side[j-1];
                for (int l = 0; l < 3; l++) begin
                    r_rem[j][l] <= n_rem[j][l];
                    r_q[j][l]   <= n_q[j][l];
                    r_low[j][l] <= r_low[j-1][l];
                    r_ovf[j][l] <= r_ovf[j-1][l];
                    r_neg[j][l] <= r_neg[j-1][l];
                end
            end
        end
    end

    // Apply the sign and saturate to the output range.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_neg[QW][l]) begin
                if (r_ovf[QW][l] || r_q[QW][l] > NEG_LIM) begin
                    o_quot[l] = t_force'(NEG_LIM);
                end else begin
                    o_quot[l] = t_force'(-r_q[QW][l]);
                end
            end else begin
                if (r_ovf[QW][l] || r_q[QW][l] > POS_LIM) begin
                    o_quot[l] = t_force'(POS_LIM);
                end else begin
                    o_quot[l] = t_force'(r_q[QW][l]);
                end
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_side  = r_side[QW];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ppf_pkg::*;

    localparam int FRAC        = 20;
    localparam int DEPTH       = 1024;
    localparam int PIPE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 1500;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_WORDS = 400;
    localparam logic [APB_AW-1:0] ADDR_CUTOFF = {REG_CUTOFF, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'b100;

    typedef struct packed {
        t_pos a_x, a_y, a_z, b_x, b_y, b_z;
    } pos_word_t;

    localparam int POS_WORD_W = $bits(pos_word_t);

    typedef struct packed {
        t_force force_x, force_y, force_z;
        logic   within_cutoff;
        logic   coincident;
    } force_word_t;

    // Scoreboard: own copy of the force table and cutoff, and a queue of expected force words.
    class force_scoreboard;
        longint            force_lut[DEPTH+1];
        logic [CUT_W-1:0]  cutoff;
        force_word_t       pending[$];
        int                errors;
        int                checked;
        int                n_within;
        int                n_coinc;

        function longint rnd_div(longint num, longint unsigned den);
            bit neg;
            longint unsigned mag, q;
            neg = num < 0;
            mag = neg ? -num : num;
            q   = (mag + den / 2) / den;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint exp_q30(longint unsigned num, longint unsigned den);
            longint          sum;
            longint unsigned term;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 20; k++) begin
                term = (term * num) / (den * k);
                if (k % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            return sum;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   -= res + b;
                    res  = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Rebuild the table as the block does after reset.
        function void build_lut();
            longint unsigned r60, r30, e60, e30;
            r60 = exp_q30(30, DEPTH);
            r30 = exp_q30(15, DEPTH);
            e60 = 64'd1 << 30;
            e30 = 64'd1 << 30;
            for (int i = 0; i <= DEPTH; i++) begin
                force_lut[i] = 4 * longint'(e60) - rnd_div(longint'(e30), 5);
                e60 = (e60 * r60 + (64'd1 << 29)) >> 30;
                e30 = (e30 * r30 + (64'd1 << 29)) >> 30;
            end
            cutoff = CUTOFF_RESET;
        endfunction

        function force_word_t pair_force(pos_word_t p);
            longint          dv[3];
            longint unsigned sq, d, ofs, idx, fr;
            longint          g, lo, hi, f;
            force_word_t     res;
            dv[0] = longint'(p.b_x) - longint'(p.a_x);
            dv[1] = longint'(p.b_y) - longint'(p.a_y);
            dv[2] = longint'(p.b_z) - longint'(p.a_z);
            sq = 0;
            for (int k = 0; k < 3; k++) sq += dv[k] * dv[k];
            d = int_sqrt(sq);
            res = '0;
            res.coincident    = dv[0] == 0 && dv[1] == 0 && dv[2] == 0;
            res.within_cutoff = d <= cutoff;
            if (res.within_cutoff && !res.coincident) begin
                ofs = d * DEPTH;
                idx = ofs >> (FRAC - 1);
                fr  = ofs & ((64'd1 << (FRAC - 1)) - 1);
                if (idx >= DEPTH) begin
                    g = force_lut[DEPTH];
                end else begin
                    lo = force_lut[idx];
                    hi = force_lut[idx+1];
                    g  = lo + rnd_div((hi - lo) * longint'(fr), 64'd1 << (FRAC - 1));
                end
                for (int k = 0; k < 3; k++) begin
                    f = rnd_div(g * dv[k], d << (30 - FRAC));
                    if (f > 8388607) f = 8388607;
                    if (f < -8388608) f = -8388608;
                    if (k == 0) res.force_x = f[23:0];
                    else if (k == 1) res.force_y = f[23:0];
                    else res.force_z = f[23:0];
                end
            end
            return res;
        endfunction

        function void note_pair(pos_word_t p);
            pending = {pending, pair_force(p)};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_force(force_word_t got);
            force_word_t exp_w;
            if (pending.size() == 0) begin
                report("force word with nothing expected");
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            n_within += exp_w.within_cutoff;
            n_coinc  += exp_w.coincident;
            if (got.force_x !== exp_w.force_x)
                report($sformatf("force_x %0d, expected %0d", got.force_x, exp_w.force_x));
            if (got.force_y !== exp_w.force_y)
                report($sformatf("force_y %0d, expected %0d", got.force_y, exp_w.force_y));
            if (got.force_z !== exp_w.force_z)
                report($sformatf("force_z %0d, expected %0d", got.force_z, exp_w.force_z));
            if (got.within_cutoff !== exp_w.within_cutoff)
                report($sformatf("within_cutoff %b, expected %b",
                                 got.within_cutoff, exp_w.within_cutoff));
            if (got.coincident !== exp_w.coincident)
                report($sformatf("coincident %b, expected %b",
                                 got.coincident, exp_w.coincident));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    ppf_in_if  pos_if ();
    ppf_out_if force_if ();

    pairwise_particle_force_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos_if),
        .o_force (force_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    force_scoreboard sb;
    int  cycles;
    bit  hold_req;
    bit  dense;
    int  sent;

    // Clock and run limit.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run limit reached");
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none while a dense stretch runs.
    function int pick_gap();
        int r;
        if (dense) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_CUTOFF) sb.cutoff = data[CUT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one position word and hold it until taken.
    task send_pair(pos_word_t p);
        int g;
        pos_if.valid <= 1'b1;
        pos_if.a_x <= p.a_x;
        pos_if.a_y <= p.a_y;
        pos_if.a_z <= p.a_z;
        pos_if.b_x <= p.b_x;
        pos_if.b_y <= p.b_y;
        pos_if.b_z <= p.b_z;
        do @(posedge i_clk); while (pos_if.ready !== 1'b1);
        sb.note_pair(p);
        sent++;
        g = pick_gap();
        if (g > 0) begin
            pos_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task send_vec(int ax, int ay, int az, int bx, int by, int bz);
        pos_word_t p;
        p.a_x = POS_W'(ax); p.a_y = POS_W'(ay); p.a_z = POS_W'(az);
        p.b_x = POS_W'(bx); p.b_y = POS_W'(by); p.b_z = POS_W'(bz);
        send_pair(p);
    endtask

    // Mostly close pairs at a random scale, some coincident, some anywhere.
    task send_random();
        pos_word_t p;
        int        r, sh;
        logic [23:0] dk[3];
        p = POS_WORD_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 75) begin
            sh = $urandom_range(0, 18);
            for (int k = 0; k < 3; k++)
                dk[k] = 24'($signed($urandom_range(0, 2 << sh)) - (1 << sh));
            p.b_x = p.a_x + dk[0];
            p.b_y = p.a_y + dk[1];
            p.b_z = p.a_z + dk[2];
        end else if (r < 85) begin
            p.b_x = p.a_x;
            p.b_y = p.a_y;
            p.b_z = p.a_z;
        end
        send_pair(p);
    endtask

    // Stop offering, then wait until every expected word has come out.
    task wait_drained();
        pos_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 10) @(posedge i_clk);
    endtask

    // Result side: samples at every edge, stalls at random, once for a long stretch.
    task watch_edge();
        force_word_t w;
        @(posedge i_clk);
        if (force_if.valid === 1'b1 && force_if.ready === 1'b1) begin
            w.force_x       = force_if.force_x;
            w.force_y       = force_if.force_y;
            w.force_z       = force_if.force_z;
            w.within_cutoff = force_if.within_cutoff;
            w.coincident    = force_if.coincident;
            sb.check_force(w);
        end
    endtask

    initial begin
        int g, hold_count;
        bit taken;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                force_if.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) watch_edge();
                hold_req = 1'b0;
            end
            g = pick_gap();
            if (g > 0) begin
                force_if.ready <= 1'b0;
                repeat (g) watch_edge();
            end
            force_if.ready <= 1'b1;
            do begin
                taken = force_if.valid === 1'b1;
                watch_edge();
            end while (!taken);
        end
    end

    // Stimulus.
    initial begin
        logic [CUT_W-1:0] cuts[RAND_PHASES];
        sb = new();
        sb.build_lut();
        cycles  = 0;
        sent    = 0;
        dense   = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        pos_if.valid <= 1'b0;
        pos_if.a_x <= '0; pos_if.a_y <= '0; pos_if.a_z <= '0;
        pos_if.b_x <= '0; pos_if.b_y <= '0; pos_if.b_z <= '0;
        force_if.ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset cutoff.
        send_vec(0, 0, 0, 0, 0, 0);
        send_vec(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
        send_vec(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
        send_vec(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
        send_vec(8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
        send_vec(0, 0, 0, 178258, 0, 0);
        send_vec(0, 0, 0, 178259, 0, 0);
        send_vec(0, 0, 0, 0, -178258, 0);
        send_vec(0, 0, 0, 0, 0, -178259);
        send_vec(100, 200, 300, 101, 200, 300);
        send_vec(100, 200, 300, 100, 199, 300);
        send_vec(100, 200, 300, 100, 200, 299);
        send_vec(0, 0, 0, 1, 1, 1);
        send_vec(0, 0, 0, -1, -1, -1);
        send_vec(-5000, 7000, 9000, 20000, -30000, 40000);
        send_vec(8388607, 0, 0, -8388608, 0, 0);
        send_vec(1000, 1000, 1000, 1000, 1000, 1000);
        send_vec(0, 0, 0, 60000, -70000, 80000);
        wait_drained();

        // A write to an unused address must leave the cutoff alone.
        cfg_write(ADDR_UNUSED, 32'd5);
        send_vec(0, 0, 0, 178258, 0, 0);
        send_vec(0, 0, 0, 10, 0, 0);
        wait_drained();

        cuts[0] = 19'd0;
        cuts[1] = 19'd262144;
        cuts[2] = 19'($urandom_range(1, 262143));
        cuts[3] = CUTOFF_RESET;
        cuts[4] = 19'($urandom_range(1000, 100000));
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(ADDR_CUTOFF, 32'(cuts[ph]));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 100 == 0) dense = $urandom_range(0, 3) == 0;
                if (ph == 1 && n == 50) hold_req = 1'b1;
                send_random();
            end
            dense = 1'b0;
            pos_if.valid <= 1'b0;
            wait_drained();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 10) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.report("force words never arrived");
        $display("covered %0d pairs, %0d checked, %0d within cutoff, %0d coincident",
                 sent, sb.checked, sb.n_within, sb.n_coinc);
        $display("cutoffs used: reset, 0, 262144 and random values; one long output stall");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_in_if.sv
hw/rtl/ppf_out_if.sv
hw/rtl/ppf_sqrt_pipe.sv
hw/rtl/ppf_div_pipe.sv
hw/rtl/pairwise_particle_force_unit.sv
tb/testbench.sv
